// ===== sv/convex_hull_area_centroid_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef CONVEX_HULL_AREA_CENTROID_DEFINES_SVH
`define CONVEX_HULL_AREA_CENTROID_DEFINES_SVH

`ifndef ASSERT_OFF
`define CHK_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHK_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(name, clk, rst_n, prop, msg)
`define CHK_IMPLY(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/chull_pkg.sv =====
package chull_pkg;

  localparam int PIX_BITS   = 12;
  localparam int COUNT_BITS = 7;
  localparam int AREA_BITS  = 25;
  localparam int CENT_BITS  = 20;

  localparam logic [AREA_BITS-1:0] AREA_MAX = '1;
  localparam logic [CENT_BITS-1:0] CENT_MAX = '1;

  typedef logic [PIX_BITS-1:0] pix_t;

endpackage

// ===== sv/chull_if.sv =====
interface chull_in_if import chull_pkg::*; ();
  logic valid;
  logic ready;
  pix_t point_x;
  pix_t point_y;
  logic last_point;

  modport source(output valid, output point_x, output point_y, output last_point,
                 input ready);
  modport sink(input valid, input point_x, input point_y, input last_point,
               output ready);
endinterface

interface chull_out_if import chull_pkg::*; ();
  logic                  valid;
  logic                  ready;
  pix_t                  vertex_x;
  pix_t                  vertex_y;
  logic                  vertex_valid;
  logic                  last_vertex;
  logic [COUNT_BITS-1:0] vertex_count;
  logic [AREA_BITS-1:0]  twice_area;
  logic [CENT_BITS-1:0]  centroid_x;
  logic [CENT_BITS-1:0]  centroid_y;
  logic                  degenerate;
  logic                  overflow;

  modport source(output valid, output vertex_x, output vertex_y, output vertex_valid,
                 output last_vertex, output vertex_count, output twice_area,
                 output centroid_x, output centroid_y, output degenerate,
                 output overflow, input ready);
  modport sink(input valid, input vertex_x, input vertex_y, input vertex_valid,
               input last_vertex, input vertex_count, input twice_area,
               input centroid_x, input centroid_y, input degenerate,
               input overflow, output ready);
endinterface

// ===== sv/chull_ram.sv =====
module chull_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/chull_div.sv =====
module chull_div import chull_pkg::*; #(
  parameter int NW = 45,
  parameter int DW = 47
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic [CENT_BITS-1:0] quo
);

  localparam int QB  = CENT_BITS;
  localparam int MW  = (NW + 8 > DW + QB) ? NW + 8 : DW + QB;
  localparam int CNW = $clog2(QB + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0]  rem_r, rem_nxt;
  logic [MW-1:0]  dsh_r, dsh_nxt;
  logic [QB-1:0]  q_r, q_nxt;
  logic           sat_r, sat_nxt;
  logic [MW-1:0]  num_sh;
  logic           ge;

  assign num_sh = MW'(num) << 8;
  assign ge     = rem_r >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    if (start) begin
      rem_nxt  = num_sh;
      dsh_nxt  = MW'(den) << (QB - 1);
      sat_nxt  = num_sh >= (MW'(den) << QB);
      q_nxt    = '0;
      cnt_nxt  = CNW'(QB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit per cycle, most significant first
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[QB-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  assign done = done_r;
  assign quo  = sat_r ? CENT_MAX : q_r;

endmodule

// ===== sv/convex_hull_area_centroid.sv =====
// A point goes straight into an empty store or is dropped by a full one; otherwise it moves stored
// points up one slot each until it finds its place (sorted insert). The last point then runs the
// hull (chain steps with pops), the shoelace sums over each hull edge, and two divisions for the
// centroid; results then follow, one per hull vertex.
// Throughput: one run at a time; points are refused while one is inserted or a run is computed
// or emitted. Reset (synchronous, rst_n low): empties the store, clears overflow and output valid.
`include "convex_hull_area_centroid_defines.svh"

module convex_hull_area_centroid import chull_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input logic         clk,
  input logic         rst_n,
  chull_in_if.sink    in_ch,
  chull_out_if.source out_ch
);

  localparam int CB  = COORD_BITS;
  localparam int PW  = 2 * CB;
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int SAW = $clog2(2 * MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int DPW = $clog2(2 * MAX_POINTS + 1);
  localparam int TW  = 2 * CB + 2;
  localparam int MXW = 3 * CB + 3;
  localparam int SW  = MXW + CW;
  localparam int DNW = SW + 2;
  localparam int AXW = SW + AREA_BITS;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INS    = 5'd1;
  localparam logic [4:0] S_PUT    = 5'd2;
  localparam logic [4:0] S_HSTART = 5'd3;
  localparam logic [4:0] S_FETCH  = 5'd4;
  localparam logic [4:0] S_GOT    = 5'd5;
  localparam logic [4:0] S_CHK    = 5'd6;
  localparam logic [4:0] S_CMP    = 5'd7;
  localparam logic [4:0] S_POPW   = 5'd8;
  localparam logic [4:0] S_ASTART = 5'd9;
  localparam logic [4:0] S_A0     = 5'd10;
  localparam logic [4:0] S_ARD    = 5'd11;
  localparam logic [4:0] S_AB     = 5'd12;
  localparam logic [4:0] S_AM1    = 5'd13;
  localparam logic [4:0] S_AM2    = 5'd14;
  localparam logic [4:0] S_AM3    = 5'd15;
  localparam logic [4:0] S_AM4    = 5'd16;
  localparam logic [4:0] S_FIN    = 5'd17;
  localparam logic [4:0] S_FIN2   = 5'd18;
  localparam logic [4:0] S_DIVX   = 5'd19;
  localparam logic [4:0] S_DIVY   = 5'd20;
  localparam logic [4:0] S_ER     = 5'd21;
  localparam logic [4:0] S_EW     = 5'd22;

  logic [4:0]            state_r, state_nxt;
  logic [PW-1:0]         key_r, key_nxt;
  logic                  last_r, last_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [PAW-1:0]        j_r, j_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [PAW-1:0]        i_r, i_nxt;
  logic                  upper_r, upper_nxt;
  logic [DPW-1:0]        d_r, d_nxt;
  logic [DPW-1:0]        floor_r, floor_nxt;
  logic [PW-1:0]         t1_r, t1_nxt;
  logic [PW-1:0]         t2_r, t2_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic signed [TW-1:0]  ta_r, ta_nxt;
  logic signed [TW-1:0]  tb_r, tb_nxt;
  logic [CW-1:0]         h_r, h_nxt;
  logic [CW-1:0]         e_r, e_nxt;
  logic [PW-1:0]         a_r, a_nxt;
  logic [PW-1:0]         b_r, b_nxt;
  logic [PW-1:0]         first_r, first_nxt;
  logic [PW-1:0]         pa_r, pa_nxt;
  logic [PW-1:0]         pb_r, pb_nxt;
  logic [CB:0]           sumx_r, sumx_nxt;
  logic [CB:0]           sumy_r, sumy_nxt;
  logic signed [PW:0]    det_r, det_nxt;
  logic signed [MXW-1:0] mx_r, mx_nxt;
  logic signed [MXW-1:0] my_r, my_nxt;
  logic signed [SW-1:0]  s_r, s_nxt;
  logic signed [SW-1:0]  sx_r, sx_nxt;
  logic signed [SW-1:0]  sy_r, sy_nxt;
  logic                  degen_r, degen_nxt;
  logic [AREA_BITS-1:0]  area_r, area_nxt;
  logic [CENT_BITS-1:0]  cx_r, cx_nxt;
  logic [CENT_BITS-1:0]  cy_r, cy_nxt;
  logic [CW-1:0]         k_r, k_nxt;

  logic                  ovalid_r, ovalid_nxt;
  pix_t                  ox_r, ox_nxt;
  pix_t                  oy_r, oy_nxt;
  logic                  ovv_r, ovv_nxt;
  logic                  olast_r, olast_nxt;
  logic [COUNT_BITS-1:0] ocnt_r, ocnt_nxt;
  logic [AREA_BITS-1:0]  oarea_r, oarea_nxt;
  logic [CENT_BITS-1:0]  ocx_r, ocx_nxt;
  logic [CENT_BITS-1:0]  ocy_r, ocy_nxt;
  logic                  odeg_r, odeg_nxt;
  logic                  oovf_r, oovf_nxt;

  // memory ports
  logic           st_we;
  logic [PAW-1:0] st_waddr, st_raddr;
  logic [PW-1:0]  st_wdata, st_rdata;
  logic           sk_we;
  logic [SAW-1:0] sk_waddr, sk_raddr;
  logic [PW-1:0]  sk_wdata, sk_rdata;

  logic                 div_start, div_done;
  logic [SW-1:0]        div_num;
  logic [DNW-1:0]       div_den;
  logic [CENT_BITS-1:0] div_quo;

  logic [CB+PIX_BITS-1:0] inx_ext, iny_ext, vx_ext, vy_ext;
  logic [CB-1:0]          px, py;
  logic signed [CB:0]     dx1, dy1, dx2, dy2;
  logic signed [TW:0]     turn_d;
  logic [CB-1:0]          ax, ay, bx, by;
  logic                   do_push;
  logic [DPW-1:0]         dm3;
  logic                   degen_now, x_ok, y_ok, c_ok;
  logic [DNW-1:0]         den3;
  logic [AXW-1:0]         s_ext;
  logic                   res_last;

  chull_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  chull_ram #(.WIDTH(PW), .DEPTH(2 * MAX_POINTS)) u_stack (
    .clk  (clk),
    .we   (sk_we),
    .waddr(sk_waddr),
    .wdata(sk_wdata),
    .raddr(sk_raddr),
    .rdata(sk_rdata)
  );

  chull_div #(.NW(SW), .DW(DNW)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign inx_ext = {{PIX_BITS{1'b0}}, in_ch.point_x};
  assign iny_ext = {{PIX_BITS{1'b0}}, in_ch.point_y};
  assign px      = inx_ext[CB-1:0];
  assign py      = iny_ext[CB-1:0];
  assign vx_ext  = {{PIX_BITS{1'b0}}, sk_rdata[PW-1:CB]};
  assign vy_ext  = {{PIX_BITS{1'b0}}, sk_rdata[CB-1:0]};

  // turn of (t2, t1, p)
  assign dx1    = $signed({1'b0, t1_r[PW-1:CB]}) - $signed({1'b0, t2_r[PW-1:CB]});
  assign dy1    = $signed({1'b0, t1_r[CB-1:0]}) - $signed({1'b0, t2_r[CB-1:0]});
  assign dx2    = $signed({1'b0, p_r[PW-1:CB]}) - $signed({1'b0, t2_r[PW-1:CB]});
  assign dy2    = $signed({1'b0, p_r[CB-1:0]}) - $signed({1'b0, t2_r[CB-1:0]});
  assign turn_d = (TW+1)'(ta_r) - (TW+1)'(tb_r);
  assign dm3    = d_r - DPW'(3);

  assign ax = a_r[PW-1:CB];
  assign ay = a_r[CB-1:0];
  assign bx = b_r[PW-1:CB];
  assign by = b_r[CB-1:0];

  assign degen_now = (h_r < CW'(2)) || (s_r == '0);
  assign x_ok      = !degen_now && !sx_r[SW-1] && (sx_r != '0);
  assign y_ok      = !degen_now && !sy_r[SW-1] && (sy_r != '0);
  assign c_ok      = (state_r == S_FIN2) ? x_ok : y_ok;
  assign den3      = (DNW'($unsigned(s_r)) << 1) + DNW'($unsigned(s_r));
  assign div_start = (state_r == S_FIN2) || ((state_r == S_DIVX) && div_done);
  assign div_num   = !c_ok ? '0 :
                     (state_r == S_FIN2) ? $unsigned(sx_r) : $unsigned(sy_r);
  assign div_den   = c_ok ? den3 : DNW'(1);
  assign s_ext     = AXW'($unsigned(s_r));
  assign res_last  = (h_r == '0) || (CW'(k_r + CW'(1)) == h_r);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    upper_nxt = upper_r;
    d_nxt     = d_r;
    floor_nxt = floor_r;
    t1_nxt    = t1_r;
    t2_nxt    = t2_r;
    p_nxt     = p_r;
    ta_nxt    = ta_r;
    tb_nxt    = tb_r;
    h_nxt     = h_r;
    e_nxt     = e_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    first_nxt = first_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    sumx_nxt  = sumx_r;
    sumy_nxt  = sumy_r;
    det_nxt   = det_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    s_nxt     = s_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    degen_nxt = degen_r;
    area_nxt  = area_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    k_nxt     = k_r;
    ovalid_nxt = ovalid_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    ovv_nxt   = ovv_r;
    olast_nxt = olast_r;
    ocnt_nxt  = ocnt_r;
    oarea_nxt = oarea_r;
    ocx_nxt   = ocx_r;
    ocy_nxt   = ocy_r;
    odeg_nxt  = odeg_r;
    oovf_nxt  = oovf_r;
    st_we     = 1'b0;
    st_waddr  = j_r;
    st_wdata  = key_r;
    st_raddr  = i_r;
    sk_we     = 1'b0;
    sk_waddr  = d_r[SAW-1:0];
    sk_wdata  = p_r;
    sk_raddr  = dm3[SAW-1:0];
    do_push   = 1'b0;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          key_nxt  = {px, py};
          last_nxt = in_ch.last_point;
          if (cnt_r == CW'(MAX_POINTS)) begin
            // store full: drop the item
            ovf_nxt   = 1'b1;
            state_nxt = in_ch.last_point ? S_HSTART : S_IDLE;
          end else if (cnt_r == '0) begin
            st_we     = 1'b1;
            st_waddr  = '0;
            st_wdata  = {px, py};
            cnt_nxt   = CW'(1);
            state_nxt = in_ch.last_point ? S_HSTART : S_IDLE;
          end else begin
            st_raddr  = PAW'(cnt_r - CW'(1));
            j_nxt     = PAW'(cnt_r);
            state_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        // keys compare as {x, y}: x first, then y
        if (key_r < st_rdata) begin
          st_we    = 1'b1;
          st_waddr = j_r;
          st_wdata = st_rdata;
          if (j_r == PAW'(1)) begin
            j_nxt     = '0;
            state_nxt = S_PUT;
          end else begin
            st_raddr = j_r - PAW'(2);
            j_nxt    = j_r - PAW'(1);
          end
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        st_we     = 1'b1;
        st_waddr  = j_r;
        st_wdata  = key_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = last_r ? S_HSTART : S_IDLE;
      end
      S_HSTART: begin
        d_nxt     = '0;
        upper_nxt = 1'b0;
        i_nxt     = '0;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        st_raddr  = i_r;
        state_nxt = S_GOT;
      end
      S_GOT: begin
        p_nxt     = st_rdata;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (upper_r ? (d_r >= floor_r) : (d_r >= DPW'(2))) begin
          ta_nxt    = dx1 * dy2;
          tb_nxt    = dy1 * dx2;
          state_nxt = S_CMP;
        end else begin
          do_push = 1'b1;
        end
      end
      S_CMP: begin
        if (turn_d[TW] || (turn_d == '0)) begin
          // pop: new second-from-top comes back from the stack memory
          d_nxt     = d_r - DPW'(1);
          t1_nxt    = t2_r;
          sk_raddr  = dm3[SAW-1:0];
          state_nxt = S_POPW;
        end else begin
          do_push = 1'b1;
        end
      end
      S_POPW: begin
        t2_nxt    = sk_rdata;
        state_nxt = S_CHK;
      end
      S_ASTART: begin
        s_nxt  = '0;
        sx_nxt = '0;
        sy_nxt = '0;
        if (h_r >= CW'(2)) begin
          sk_raddr  = '0;
          state_nxt = S_A0;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_A0: begin
        a_nxt     = sk_rdata;
        first_nxt = sk_rdata;
        e_nxt     = CW'(1);
        state_nxt = S_ARD;
      end
      S_ARD: begin
        sk_raddr  = SAW'(e_r);
        state_nxt = S_AB;
      end
      S_AB: begin
        // closing edge wraps to the first vertex
        b_nxt     = (e_r == h_r) ? first_r : sk_rdata;
        state_nxt = S_AM1;
      end
      S_AM1: begin
        pa_nxt    = ax * by;
        pb_nxt    = bx * ay;
        sumx_nxt  = {1'b0, ax} + {1'b0, bx};
        sumy_nxt  = {1'b0, ay} + {1'b0, by};
        state_nxt = S_AM2;
      end
      S_AM2: begin
        det_nxt   = $signed({1'b0, pa_r}) - $signed({1'b0, pb_r});
        state_nxt = S_AM3;
      end
      S_AM3: begin
        mx_nxt    = det_r * $signed({1'b0, sumx_r});
        my_nxt    = det_r * $signed({1'b0, sumy_r});
        s_nxt     = s_r + SW'(det_r);
        state_nxt = S_AM4;
      end
      S_AM4: begin
        sx_nxt = sx_r + SW'(mx_r);
        sy_nxt = sy_r + SW'(my_r);
        a_nxt  = b_r;
        if (e_r == h_r) begin
          state_nxt = S_FIN;
        end else begin
          e_nxt     = e_r + CW'(1);
          state_nxt = S_ARD;
        end
      end
      S_FIN: begin
        if (s_r[SW-1]) begin
          s_nxt  = -s_r;
          sx_nxt = -sx_r;
          sy_nxt = -sy_r;
        end
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        degen_nxt = degen_now;
        area_nxt  = (s_ext > AXW'(AREA_MAX)) ? AREA_MAX : s_ext[AREA_BITS-1:0];
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        if (div_done) begin
          cx_nxt    = div_quo;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          cy_nxt    = div_quo;
          k_nxt     = '0;
          state_nxt = S_ER;
        end
      end
      S_ER: begin
        if (!ovalid_r || out_ch.ready) begin
          sk_raddr  = SAW'(k_r);
          state_nxt = S_EW;
        end
      end
      S_EW: begin
        ovalid_nxt = 1'b1;
        ovv_nxt    = (h_r != '0);
        ox_nxt     = (h_r != '0) ? vx_ext[PIX_BITS-1:0] : '0;
        oy_nxt     = (h_r != '0) ? vy_ext[PIX_BITS-1:0] : '0;
        olast_nxt  = res_last;
        ocnt_nxt   = COUNT_BITS'(h_r);
        oarea_nxt  = res_last ? area_r : '0;
        ocx_nxt    = (res_last && !degen_r) ? cx_r : '0;
        ocy_nxt    = (res_last && !degen_r) ? cy_r : '0;
        odeg_nxt   = res_last && degen_r;
        oovf_nxt   = res_last && ovf_r;
        k_nxt      = k_r + CW'(1);
        if (res_last) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ER;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_push) begin
      sk_we    = 1'b1;
      sk_waddr = d_r[SAW-1:0];
      sk_wdata = p_r;
      d_nxt    = d_r + DPW'(1);
      t2_nxt   = t1_r;
      t1_nxt   = p_r;
      if (!upper_r) begin
        if (CW'(i_r) == cnt_r - CW'(1)) begin
          if (cnt_r == CW'(1)) begin
            h_nxt     = CW'(1);
            state_nxt = S_ASTART;
          end else begin
            upper_nxt = 1'b1;
            floor_nxt = d_r + DPW'(2);
            i_nxt     = PAW'(cnt_r - CW'(2));
            state_nxt = S_FETCH;
          end
        end else begin
          i_nxt     = i_r + PAW'(1);
          state_nxt = S_FETCH;
        end
      end else if (i_r == '0) begin
        // start point closes the upper chain and is not counted twice
        h_nxt     = CW'(d_r);
        state_nxt = S_ASTART;
      end else begin
        i_nxt     = i_r - PAW'(1);
        state_nxt = S_FETCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
    key_r   <= key_nxt;
    last_r  <= last_nxt;
    j_r     <= j_nxt;
    i_r     <= i_nxt;
    upper_r <= upper_nxt;
    d_r     <= d_nxt;
    floor_r <= floor_nxt;
    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    p_r     <= p_nxt;
    ta_r    <= ta_nxt;
    tb_r    <= tb_nxt;
    h_r     <= h_nxt;
    e_r     <= e_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    first_r <= first_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    sumx_r  <= sumx_nxt;
    sumy_r  <= sumy_nxt;
    det_r   <= det_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    s_r     <= s_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    degen_r <= degen_nxt;
    area_r  <= area_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    k_r     <= k_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    ovv_r   <= ovv_nxt;
    olast_r <= olast_nxt;
    ocnt_r  <= ocnt_nxt;
    oarea_r <= oarea_nxt;
    ocx_r   <= ocx_nxt;
    ocy_r   <= ocy_nxt;
    odeg_r  <= odeg_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.vertex_x     = ox_r;
  assign out_ch.vertex_y     = oy_r;
  assign out_ch.vertex_valid = ovv_r;
  assign out_ch.last_vertex  = olast_r;
  assign out_ch.vertex_count = ocnt_r;
  assign out_ch.twice_area   = oarea_r;
  assign out_ch.centroid_x   = ocx_r;
  assign out_ch.centroid_y   = ocy_r;
  assign out_ch.degenerate   = odeg_r;
  assign out_ch.overflow     = oovf_r;

  `CHK_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(MAX_POINTS), "store count past depth")
  `CHK_IMPLY(a_pop_depth, clk, rst_n, state_r == S_CMP, d_r >= DPW'(2), "turn test on short stack")
  `CHK_IMPLY(a_div_owner, clk, rst_n, div_done, (state_r == S_DIVX) || (state_r == S_DIVY), "stray divider done")
  `CHK_IMPLY(a_push_room, clk, rst_n, sk_we, d_r < DPW'(2 * MAX_POINTS), "chain stack overrun")

endmodule
